### sv/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none
package u8sd_pkg;

    localparam int unsigned CP_W  = 31;
    localparam int unsigned REM_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            truncated;
        logic            text_end;
    } t_out_item;

    typedef struct packed {
        logic [CP_W-1:0]  partial_value;
        logic [REM_W-1:0] bytes_remaining;
    } t_dec_state;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_dec_result;

    localparam logic [7:0] LEAD6 = 8'hFC;
    localparam logic [7:0] LEAD5 = 8'hF8;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] PAY6  = 8'h01;
    localparam logic [7:0] PAY5  = 8'h03;
    localparam logic [7:0] PAY4  = 8'h07;
    localparam logic [7:0] PAY3  = 8'h0F;
    localparam logic [7:0] PAY2  = 8'h1F;
    localparam logic [7:0] CONT_MASK = 8'h3F;

endpackage
`default_nettype wire

### sv/u8sd_core.sv
// Decode step: next sequence state and optional result for one byte.
`default_nettype none
module u8sd_core (
    input  wire  u8sd_pkg::t_dec_state  i_state,
    input  wire  u8sd_pkg::t_in_item    i_item,
    output u8sd_pkg::t_dec_state        o_state,
    output u8sd_pkg::t_dec_result       o_result
);
    import u8sd_pkg::*;

    logic [7:0]       w_b;
    logic [7:0]       w_payload;
    logic [REM_W-1:0] w_more;
    logic [CP_W-1:0]  w_shifted;
    logic [REM_W-1:0] w_rem_dec;

    assign w_b       = i_item.data_byte;
    assign w_shifted = {i_state.partial_value[CP_W-7:0], w_b[5:0] & CONT_MASK[5:0]};
    assign w_rem_dec = i_state.bytes_remaining - REM_W'(1);

    always_comb begin
        if ((w_b & LEAD6) == LEAD6) begin
            w_payload = w_b & PAY6;
            w_more    = REM_W'(5);
        end else if ((w_b & LEAD5) == LEAD5) begin
            w_payload = w_b & PAY5;
            w_more    = REM_W'(4);
        end else if ((w_b & LEAD4) == LEAD4) begin
            w_payload = w_b & PAY4;
            w_more    = REM_W'(3);
        end else if ((w_b & LEAD3) == LEAD3) begin
            w_payload = w_b & PAY3;
            w_more    = REM_W'(2);
        end else if ((w_b & LEAD2) == LEAD2) begin
            w_payload = w_b & PAY2;
            w_more    = REM_W'(1);
        end else begin
            w_payload = w_b;
            w_more    = '0;
        end
    end

    always_comb begin
        o_state                     = '0;
        o_result.valid              = 1'b0;
        o_result.item.code_point    = '0;
        o_result.item.truncated     = 1'b0;
        o_result.item.text_end      = i_item.end_of_text;
        if (i_state.bytes_remaining == '0) begin
            o_result.item.code_point = CP_W'(w_payload);
            if (w_more == '0) begin
                o_result.valid = 1'b1;
            end else if (i_item.end_of_text) begin
                o_result.valid          = 1'b1;
                o_result.item.truncated = 1'b1;
            end else begin
                o_state.partial_value   = CP_W'(w_payload);
                o_state.bytes_remaining = w_more;
            end
        end else begin
            o_result.item.code_point = w_shifted;
            if (w_rem_dec == '0) begin
                o_result.valid = 1'b1;
            end else if (i_item.end_of_text) begin
                o_result.valid          = 1'b1;
                o_result.item.truncated = 1'b1;
            end else begin
                o_state.partial_value   = w_shifted;
                o_state.bytes_remaining = w_rem_dec;
            end
        end
    end

endmodule
`default_nettype wire

### sv/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input register, decode step, result register.
// A completing byte passes through the input register, and its result is then held in the result register.
// Throughput: one byte per cycle; bytes that complete no sequence keep flowing while a
// finished result waits, and a completing byte holds in the input register until then.
// The sequence state updates once per byte through a single decode step.
// Reset (synchronous, active low) empties both registers and clears the state.
`default_nettype none
module utf8_stream_decoder (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  u8sd_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output u8sd_pkg::t_out_item    o_out_item
);
    import u8sd_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    t_dec_state  r_state;
    t_dec_state  n_state;
    logic        r_out_valid;
    t_out_item   r_out;
    t_dec_result w_res;
    logic        w_out_free;
    logic        w_adv;

    u8sd_core u_core (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (w_res)
    );

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_adv       = r_in_valid && (!w_res.valid || w_out_free);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_state <= n_state;
            end
            if (w_adv && w_res.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (w_adv && w_res.valid) begin
            r_out <= w_res.item;
        end
    end

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_remaining <= REM_W'(5))
        else $error("sequence count out of range");

    a_trunc_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.truncated || r_out.text_end))
        else $error("truncated result without end of text");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in)))
        else $error("held input item lost");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule
`default_nettype wire
